// ----- rtl/formula_token_lexer_assert.svh -----
// Assertion macros shared by the checker of the formula lexer.
// No dependencies; included by files that hold concurrent assertions.
`ifndef FORMULA_TOKEN_LEXER_ASSERT_SVH
`define FORMULA_TOKEN_LEXER_ASSERT_SVH

// Checked on every rising edge outside reset.
`define FMLX_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define FMLX_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/fmlx_pkg.sv -----
// Types, constants and character helpers of the formula lexer.
// No dependencies; used by the queue, front, back end, top level and checker.
package fmlx_pkg;

	localparam int IDENT_DEPTH = 32;
	localparam int LEN_W       = $clog2(IDENT_DEPTH + 1);
	localparam int ADDR_W      = $clog2(IDENT_DEPTH);
	localparam int MAX_ENT     = 6;
	localparam int ENT_W       = $clog2(MAX_ENT);
	localparam int QDEPTH      = 4;
	localparam int Q_AW        = $clog2(QDEPTH);

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_COLON  = 8'h3a;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_DOT    = 8'h2e;
	localparam logic [7:0] CH_EQ     = 8'h3d;
	localparam logic [7:0] CH_LT     = 8'h3c;
	localparam logic [7:0] CH_GT     = 8'h3e;
	localparam logic [7:0] CH_PLUS   = 8'h2b;
	localparam logic [7:0] CH_MINUS  = 8'h2d;

	typedef enum logic [3:0] {
		K_NUMBER = 4'd0, K_STRING = 4'd1, K_BOOL = 4'd2, K_CELL = 4'd3,
		K_RANGE = 4'd4, K_FUNC = 4'd5, K_LPAREN = 4'd6, K_RPAREN = 4'd7,
		K_COMMA = 4'd8, K_OPER = 4'd9, K_END = 4'd10
	} kind_t;

	typedef enum logic [3:0] {
		M_IDLE, M_NUM, M_NUM_E, M_NUM_EXP, M_STR, M_STR_Q, M_DOT, M_OP,
		M_ID, M_ID_COLON, M_ID_RANGE
	} mode_t;

	typedef enum logic [2:0] {
		S_START, S_DOL1, S_LET, S_DOL2, S_DIG, S_FAIL
	} shape_t;

	typedef enum logic {B_POP, B_REP} back_state_t;

	// One queue entry: a finished beat, or a request to replay the identifier store.
	typedef struct packed {
		logic             replay;
		kind_t            kind;
		logic [7:0]       ch;
		logic             close;
		logic             trunc;
		logic             last;
		logic [LEN_W-1:0] len;
	} cmd_t;

	function automatic logic is_digit(logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_letter(logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a);
	endfunction

	function automatic logic is_ident(logic [7:0] c);
		return c == CH_DOLLAR || is_letter(c) || is_digit(c);
	endfunction

	function automatic logic [7:0] upper(logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7a) ? c - 8'd32 : c;
	endfunction

	// TRUE when sel is 0, FALSE when sel is 1
	function automatic logic [7:0] word_char(logic sel, logic [2:0] i);
		logic [7:0] r;
		r = 8'h00;
		if (!sel) begin
			case (i)
				3'd0: r = 8'h54;
				3'd1: r = 8'h52;
				3'd2: r = 8'h55;
				3'd3: r = 8'h45;
				default: r = 8'h00;
			endcase
		end else begin
			case (i)
				3'd0: r = 8'h46;
				3'd1: r = 8'h41;
				3'd2: r = 8'h4c;
				3'd3: r = 8'h53;
				3'd4: r = 8'h45;
				default: r = 8'h00;
			endcase
		end
		return r;
	endfunction

	function automatic shape_t track_shape(shape_t s, logic [7:0] c);
		shape_t r;
		case (s)
			S_START: r = (c == CH_DOLLAR) ? S_DOL1 : is_letter(c) ? S_LET : S_FAIL;
			S_DOL1:  r = is_letter(c) ? S_LET : S_FAIL;
			S_LET:   r = is_letter(c) ? S_LET : (c == CH_DOLLAR) ? S_DOL2 :
				is_digit(c) ? S_DIG : S_FAIL;
			S_DOL2:  r = is_digit(c) ? S_DIG : S_FAIL;
			S_DIG:   r = is_digit(c) ? S_DIG : S_FAIL;
			default: r = S_FAIL;
		endcase
		return r;
	endfunction

	function automatic cmd_t mk_beat(kind_t kind, logic [7:0] ch, logic close);
		cmd_t r;
		r        = '0;
		r.kind   = kind;
		r.ch     = close ? 8'h00 : ch;
		r.close  = close;
		return r;
	endfunction

	function automatic cmd_t mk_replay(kind_t kind, logic [LEN_W-1:0] len, logic trunc);
		cmd_t r;
		r        = '0;
		r.replay = 1'b1;
		r.kind   = kind;
		r.len    = len;
		r.trunc  = trunc;
		return r;
	endfunction

endpackage

// ----- rtl/fmlx_if.sv -----
// Handshake channels of the formula lexer: input bytes and token beats.
// Depends on nothing.
interface fmlx_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       ch_valid;
	logic       expr_last;
	modport source (output valid, ch, ch_valid, expr_last, input ready);
	modport sink (input valid, ch, ch_valid, expr_last, output ready);
endinterface

interface fmlx_tok_if;
	logic       valid;
	logic       ready;
	logic [3:0] token_kind;
	logic [7:0] text_char;
	logic       is_close;
	logic       truncated;
	logic       run_last;
	modport source (output valid, token_kind, text_char, is_close, truncated, run_last,
		input ready);
	modport sink (input valid, token_kind, text_char, is_close, truncated, run_last,
		output ready);
endinterface

// ----- rtl/fmlx_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fmlx_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

// ----- rtl/fmlx_fifo.sv -----
// Short command queue between the lexer front and the token back end.
// Depends on fmlx_pkg.
module fmlx_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  fmlx_pkg::cmd_t din,
	output logic          full,
	input  logic          pop,
	output fmlx_pkg::cmd_t dout,
	output logic          empty
);
	import fmlx_pkg::*;

	cmd_t          buf_q [QDEPTH];
	logic [Q_AW-1:0] wp_q, rp_q;
	logic [Q_AW:0]   cnt_q;

	assign full  = cnt_q == (Q_AW+1)'(QDEPTH);
	assign empty = cnt_q == '0;
	assign dout  = buf_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) buf_q[wp_q] <= din;
	end
endmodule

// ----- rtl/fmlx_front.sv -----
// Lexer front end: takes input bytes, runs the lexing state, fills the
// identifier store and queues beats or replay requests. Depends on fmlx_pkg.
module fmlx_front (
	input  logic                        clk,
	input  logic                        arst_n,
	fmlx_char_if.sink                   chars,
	output logic                        push,
	output fmlx_pkg::cmd_t              push_cmd,
	input  logic                        q_full,
	input  logic                        replay_done,
	output logic                        ram_we,
	output logic [fmlx_pkg::ADDR_W-1:0] ram_waddr,
	output logic [7:0]                  ram_wdata
);
	import fmlx_pkg::*;

	mode_t            mode_q, m;
	shape_t           shape_q, sh;
	logic [7:0]       held_q, hb, c;
	logic [LEN_W-1:0] len_q, len;
	logic             ovf_q, ovf, mt_q, mt, mf_q, mf;
	logic [2:0]       nd_q, nd;
	logic             busy_q;
	cmd_t             ent_q [MAX_ENT];
	cmd_t             ent [MAX_ENT];
	logic [ENT_W-1:0] cnt_q, ptr_q, k;
	logic             restart, st_en, trk, we, has_rep, accept;
	logic [ADDR_W-1:0] waddr;
	logic [7:0]       wdata;

	function automatic cmd_t plain_cmd(logic [LEN_W-1:0] l, logic o, shape_t s,
		logic t, logic f, logic [2:0] n);
		cmd_t r;
		if (!o && t && n == 3'd4) r = mk_replay(K_BOOL, LEN_W'(4), 1'b0);
		else if (!o && f && n == 3'd5) r = mk_replay(K_BOOL, LEN_W'(5), 1'b0);
		else if (s == S_DIG) r = mk_replay(K_CELL, l, o);
		else r = mk_replay(K_FUNC, l, o);
		return r;
	endfunction

	assign chars.ready = (ptr_q == cnt_q) && !busy_q;
	assign accept      = chars.valid && chars.ready;

	always_comb begin
		c       = chars.ch;
		m       = mode_q;
		hb      = held_q;
		len     = len_q;
		ovf     = ovf_q;
		sh      = shape_q;
		mt      = mt_q;
		mf      = mf_q;
		nd      = nd_q;
		k       = '0;
		restart = 1'b0;
		st_en   = 1'b0;
		trk     = 1'b0;
		we      = 1'b0;
		waddr   = '0;
		wdata   = 8'h00;
		has_rep = 1'b0;
		for (int i = 0; i < MAX_ENT; i++) ent[i] = '0;

		if (chars.ch_valid) begin
			case (m)
				M_NUM: begin
					if (is_digit(c) || c == CH_DOT) begin
						ent[k] = mk_beat(K_NUMBER, c, 1'b0); k = k + 1'b1;
					end else if (c == 8'h65 || c == 8'h45) begin
						ent[k] = mk_beat(K_NUMBER, c, 1'b0); k = k + 1'b1;
						m = M_NUM_E;
					end else begin
						ent[k] = mk_beat(K_NUMBER, 8'h00, 1'b1); k = k + 1'b1;
						restart = 1'b1;
					end
				end
				M_NUM_E: begin
					if (c == CH_PLUS || c == CH_MINUS || is_digit(c)) begin
						ent[k] = mk_beat(K_NUMBER, c, 1'b0); k = k + 1'b1;
						m = M_NUM_EXP;
					end else begin
						ent[k] = mk_beat(K_NUMBER, 8'h00, 1'b1); k = k + 1'b1;
						restart = 1'b1;
					end
				end
				M_NUM_EXP: begin
					if (is_digit(c)) begin
						ent[k] = mk_beat(K_NUMBER, c, 1'b0); k = k + 1'b1;
					end else begin
						ent[k] = mk_beat(K_NUMBER, 8'h00, 1'b1); k = k + 1'b1;
						restart = 1'b1;
					end
				end
				M_STR: begin
					if (c == CH_QUOTE) m = M_STR_Q;
					else begin
						ent[k] = mk_beat(K_STRING, c, 1'b0); k = k + 1'b1;
					end
				end
				M_STR_Q: begin
					if (c == CH_QUOTE) begin
						ent[k] = mk_beat(K_STRING, c, 1'b0); k = k + 1'b1;
						m = M_STR;
					end else begin
						ent[k] = mk_beat(K_STRING, 8'h00, 1'b1); k = k + 1'b1;
						restart = 1'b1;
					end
				end
				M_DOT: begin
					if (is_digit(c)) begin
						ent[k] = mk_beat(K_NUMBER, CH_DOT, 1'b0); k = k + 1'b1;
						ent[k] = mk_beat(K_NUMBER, c, 1'b0); k = k + 1'b1;
						m = M_NUM;
					end else restart = 1'b1;
				end
				M_OP: begin
					ent[k] = mk_beat(K_OPER, hb, 1'b0); k = k + 1'b1;
					if (c == CH_EQ || c == CH_GT) begin
						ent[k] = mk_beat(K_OPER, c, 1'b0); k = k + 1'b1;
						ent[k] = mk_beat(K_OPER, 8'h00, 1'b1); k = k + 1'b1;
						m = M_IDLE;
					end else begin
						ent[k] = mk_beat(K_OPER, 8'h00, 1'b1); k = k + 1'b1;
						restart = 1'b1;
					end
				end
				M_ID: begin
					if (is_ident(c)) begin
						st_en = 1'b1;
						trk   = 1'b1;
					end else if (c == CH_COLON) begin
						// colon written ahead; it only counts if the range goes on
						if (len < LEN_W'(IDENT_DEPTH)) begin
							we    = 1'b1;
							waddr = len[ADDR_W-1:0];
							wdata = CH_COLON;
						end
						m = M_ID_COLON;
					end else begin
						ent[k] = plain_cmd(len, ovf, sh, mt, mf, nd); k = k + 1'b1;
						restart = 1'b1;
					end
				end
				M_ID_COLON: begin
					if (is_ident(c)) begin
						if (len < LEN_W'(IDENT_DEPTH)) len = len + 1'b1;
						else ovf = 1'b1;
						st_en = 1'b1;
						m     = M_ID_RANGE;
					end else begin
						ent[k] = plain_cmd(len, ovf, sh, mt, mf, nd); k = k + 1'b1;
						restart = 1'b1;
					end
				end
				M_ID_RANGE: begin
					if (is_ident(c)) st_en = 1'b1;
					else begin
						ent[k] = mk_replay(K_RANGE, len, ovf); k = k + 1'b1;
						restart = 1'b1;
					end
				end
				default: restart = 1'b1;
			endcase

			if (restart) begin
				m = M_IDLE;
				if (c == CH_QUOTE) m = M_STR;
				else if (is_digit(c)) begin
					ent[k] = mk_beat(K_NUMBER, c, 1'b0); k = k + 1'b1;
					m = M_NUM;
				end else if (c == CH_DOT) m = M_DOT;
				else if (c == CH_DOLLAR || is_letter(c)) begin
					len   = '0;
					ovf   = 1'b0;
					sh    = S_START;
					mt    = 1'b1;
					mf    = 1'b1;
					nd    = '0;
					st_en = 1'b1;
					trk   = 1'b1;
					m     = M_ID;
				end else if (c == 8'h28) begin
					ent[k] = mk_beat(K_LPAREN, c, 1'b0); k = k + 1'b1;
					ent[k] = mk_beat(K_LPAREN, 8'h00, 1'b1); k = k + 1'b1;
				end else if (c == 8'h29) begin
					ent[k] = mk_beat(K_RPAREN, c, 1'b0); k = k + 1'b1;
					ent[k] = mk_beat(K_RPAREN, 8'h00, 1'b1); k = k + 1'b1;
				end else if (c == 8'h2c) begin
					ent[k] = mk_beat(K_COMMA, c, 1'b0); k = k + 1'b1;
					ent[k] = mk_beat(K_COMMA, 8'h00, 1'b1); k = k + 1'b1;
				end else if (c == CH_PLUS || c == CH_MINUS || c == 8'h2a || c == 8'h2f ||
					c == 8'h5e || c == 8'h26 || c == 8'h25) begin
					ent[k] = mk_beat(K_OPER, c, 1'b0); k = k + 1'b1;
					ent[k] = mk_beat(K_OPER, 8'h00, 1'b1); k = k + 1'b1;
				end else if (c == CH_LT || c == CH_GT || c == CH_EQ) begin
					hb = c;
					m  = M_OP;
				end
			end

			if (st_en) begin
				if (len < LEN_W'(IDENT_DEPTH)) begin
					we    = 1'b1;
					waddr = len[ADDR_W-1:0];
					wdata = c;
					len   = len + 1'b1;
					// TRUE/FALSE match over stored bytes, '$' ignored
					if (c != CH_DOLLAR) begin
						if (nd < 3'd5) begin
							mt = mt && nd < 3'd4 && upper(c) == word_char(1'b0, nd);
							mf = mf && upper(c) == word_char(1'b1, nd);
						end else begin
							mt = 1'b0;
							mf = 1'b0;
						end
						if (nd < 3'd6) nd = nd + 1'b1;
					end
				end else ovf = 1'b1;
			end
			if (trk) sh = track_shape(sh, c);
		end

		if (chars.expr_last) begin
			case (m)
				M_NUM, M_NUM_E, M_NUM_EXP: begin
					ent[k] = mk_beat(K_NUMBER, 8'h00, 1'b1); k = k + 1'b1;
				end
				M_STR, M_STR_Q: begin
					ent[k] = mk_beat(K_STRING, 8'h00, 1'b1); k = k + 1'b1;
				end
				M_OP: begin
					ent[k] = mk_beat(K_OPER, hb, 1'b0); k = k + 1'b1;
					ent[k] = mk_beat(K_OPER, 8'h00, 1'b1); k = k + 1'b1;
				end
				M_ID, M_ID_COLON: begin
					ent[k] = plain_cmd(len, ovf, sh, mt, mf, nd); k = k + 1'b1;
				end
				M_ID_RANGE: begin
					ent[k] = mk_replay(K_RANGE, len, ovf); k = k + 1'b1;
				end
				default: ;
			endcase
			ent[k] = mk_beat(K_END, 8'h00, 1'b1); k = k + 1'b1;
			m = M_IDLE;
		end

		if (k != '0) ent[k - 1'b1].last = 1'b1;
		for (int i = 0; i < MAX_ENT; i++) has_rep = has_rep | ent[i].replay;
	end

	assign ram_we    = accept && we;
	assign ram_waddr = waddr;
	assign ram_wdata = wdata;
	assign push      = (ptr_q != cnt_q) && !q_full;
	assign push_cmd  = ent_q[ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			held_q  <= 8'h00;
			len_q   <= '0;
			ovf_q   <= 1'b0;
			shape_q <= S_START;
			mt_q    <= 1'b0;
			mf_q    <= 1'b0;
			nd_q    <= '0;
			busy_q  <= 1'b0;
			cnt_q   <= '0;
			ptr_q   <= '0;
		end else begin
			if (accept) begin
				mode_q  <= m;
				held_q  <= hb;
				len_q   <= len;
				ovf_q   <= ovf;
				shape_q <= sh;
				mt_q    <= mt;
				mf_q    <= mf;
				nd_q    <= nd;
				cnt_q   <= k;
				ptr_q   <= '0;
			end else if (push) begin
				ptr_q <= ptr_q + 1'b1;
			end
			// store is locked from the accept that queues a replay until it is read out
			if (accept && has_rep) busy_q <= 1'b1;
			else if (replay_done) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < MAX_ENT; i++) ent_q[i] <= ent[i];
		end
	end
endmodule

// ----- rtl/fmlx_back.sv -----
// Token back end: pops queued commands, replays the identifier store
// through the RAM read port and drives the output register. Depends on fmlx_pkg.
module fmlx_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_empty,
	input  fmlx_pkg::cmd_t              q_head,
	output logic                        pop,
	output logic [fmlx_pkg::ADDR_W-1:0] ram_raddr,
	input  logic [7:0]                  ram_rdata,
	output logic                        replay_done,
	fmlx_tok_if.source                  tokens
);
	import fmlx_pkg::*;

	back_state_t      st_q, st_d;
	cmd_t             cmd_q;
	logic [LEN_W-1:0] idx_q, idx_d;
	logic             dok_q, dok_d;
	logic             ovalid_q, ld, load;
	kind_t            okind_q, okind_d;
	logic [7:0]       ochar_q, ochar_d;
	logic             oclose_q, oclose_d, otrunc_q, otrunc_d, olast_q, olast_d;

	assign ld        = !ovalid_q || tokens.ready;
	assign ram_raddr = idx_q[ADDR_W-1:0];

	always_comb begin
		st_d        = st_q;
		idx_d       = idx_q;
		dok_d       = dok_q;
		pop         = 1'b0;
		load        = 1'b0;
		replay_done = 1'b0;
		okind_d     = cmd_q.kind;
		ochar_d     = 8'h00;
		oclose_d    = 1'b0;
		otrunc_d    = 1'b0;
		olast_d     = 1'b0;
		case (st_q)
			B_POP: begin
				if (!q_empty && ld) begin
					pop = 1'b1;
					if (q_head.replay) begin
						st_d  = B_REP;
						idx_d = '0;
						dok_d = 1'b0;
					end else begin
						load     = 1'b1;
						okind_d  = q_head.kind;
						ochar_d  = q_head.ch;
						oclose_d = q_head.close;
						otrunc_d = q_head.trunc;
						olast_d  = q_head.last;
					end
				end
			end
			B_REP: begin
				if (idx_q == cmd_q.len) begin
					if (ld) begin
						load        = 1'b1;
						oclose_d    = 1'b1;
						otrunc_d    = cmd_q.trunc;
						olast_d     = cmd_q.last;
						replay_done = 1'b1;
						st_d        = B_POP;
					end
				end else if (cmd_q.kind == K_BOOL) begin
					if (ld) begin
						load    = 1'b1;
						ochar_d = word_char(cmd_q.len == LEN_W'(5), idx_q[2:0]);
						idx_d   = idx_q + 1'b1;
					end
				end else if (!dok_q) begin
					dok_d = 1'b1;
				end else if (cmd_q.kind == K_CELL && ram_rdata == CH_DOLLAR) begin
					idx_d = idx_q + 1'b1;
					dok_d = 1'b0;
				end else if (ld) begin
					load    = 1'b1;
					ochar_d = (cmd_q.kind == K_RANGE) ? ram_rdata : upper(ram_rdata);
					idx_d   = idx_q + 1'b1;
					dok_d   = 1'b0;
				end
			end
			default: st_d = B_POP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= B_POP;
			idx_q    <= '0;
			dok_q    <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			st_q  <= st_d;
			idx_q <= idx_d;
			dok_q <= dok_d;
			if (ld) ovalid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) cmd_q <= q_head;
		if (load) begin
			okind_q  <= okind_d;
			ochar_q  <= ochar_d;
			oclose_q <= oclose_d;
			otrunc_q <= otrunc_d;
			olast_q  <= olast_d;
		end
	end

	assign tokens.valid      = ovalid_q;
	assign tokens.token_kind = 4'(okind_q);
	assign tokens.text_char  = ochar_q;
	assign tokens.is_close   = oclose_q;
	assign tokens.truncated  = otrunc_q;
	assign tokens.run_last   = olast_q;
endmodule

// ----- rtl/formula_token_lexer.sv -----
// Formula lexer: ASCII bytes in, token beats (text bytes plus a close beat) out.
// Uses the package, channels, RAM, queue, front and back end modules.
//
// chars:  one beat per formula byte (ch, ch_valid); expr_last closes any open
//         token and appends the End token. ch_valid = 0 with expr_last = 0 is
//         an empty beat with no output.
// tokens: token_kind, text_char, is_close, truncated, run_last per beat;
//         run_last marks the last beat caused by one input beat.
// Throughput: the front takes no new byte until it has pushed every entry queued
// for the last one; it pushes one entry per cycle while the queue is not full,
// up to five per byte.
// Identifiers go to a 32-byte store and are replayed on the byte that ends
// them, each stored byte read through the registered RAM read port, and
// the front takes no new byte until that replay has been read out.
// Path: entries are registered in the front, pass the queue and are loaded
// into the output register; a replayed TRUE/FALSE skips the store read.
// Reset: arst_n clears lexing state, queue and output register; no clearing
// pass, the store is only read below the current identifier length.
// Stall: a held tokens.ready freezes the output register; the queue fills,
// then chars.ready drops. No beat is lost or repeated.
module formula_token_lexer (
	input  logic        clk,
	input  logic        arst_n,
	fmlx_char_if.sink   chars,
	fmlx_tok_if.source  tokens
);
	import fmlx_pkg::*;

	logic              push, pop, q_full, q_empty, replay_done;
	cmd_t              push_cmd, q_head;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr, ram_raddr;
	logic [7:0]        ram_wdata, ram_rdata;

	// front: lexing state, store writes, command generation
	fmlx_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.chars       (chars),
		.push        (push),
		.push_cmd    (push_cmd),
		.q_full      (q_full),
		.replay_done (replay_done),
		.ram_we      (ram_we),
		.ram_waddr   (ram_waddr),
		.ram_wdata   (ram_wdata)
	);

	// decouples lexing from beat delivery
	fmlx_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (push_cmd),
		.full   (q_full),
		.pop    (pop),
		.dout   (q_head),
		.empty  (q_empty)
	);

	// identifier store
	fmlx_ram #(
		.WIDTH (8),
		.DEPTH (IDENT_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// back: replay and output register
	fmlx_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_head      (q_head),
		.pop         (pop),
		.ram_raddr   (ram_raddr),
		.ram_rdata   (ram_rdata),
		.replay_done (replay_done),
		.tokens      (tokens)
	);
endmodule

// ----- rtl/fmlx_checker.sv -----
// Port-level checks of the formula lexer and their bind to the top level.
// Depends on fmlx_pkg and formula_token_lexer_assert.svh.
`include "formula_token_lexer_assert.svh"

module fmlx_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       tok_valid,
	input logic       tok_ready,
	input logic [3:0] token_kind,
	input logic [7:0] text_char,
	input logic       is_close,
	input logic       truncated,
	input logic       run_last
);
	import fmlx_pkg::*;

	`FMLX_ASSERT(a_text_no_trunc, tok_valid && !is_close |-> !truncated, "truncated on text beat")
	`FMLX_ASSERT(a_end_closes, tok_valid && token_kind == 4'(K_END) |-> is_close && run_last, "End beat not final close")
	`FMLX_ASSERT(a_close_no_text, tok_valid && is_close |-> text_char == 8'h00 && token_kind <= 4'(K_END), "bad close beat")
	`FMLX_ASSERT(a_hold, tok_valid && !tok_ready |=> tok_valid && $stable(token_kind) && $stable(text_char) && $stable(is_close), "beat changed under stall")
	`FMLX_ASSERT_RST(a_reset_quiet, !arst_n |=> !tok_valid, "output valid right after reset")
endmodule

bind formula_token_lexer fmlx_checker u_fmlx_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.tok_valid  (tokens.valid),
	.tok_ready  (tokens.ready),
	.token_kind (tokens.token_kind),
	.text_char  (tokens.text_char),
	.is_close   (tokens.is_close),
	.truncated  (tokens.truncated),
	.run_last   (tokens.run_last)
);
